>>> rtl/mqs_pkg.sv
// Shared types and codes of the multilevel quota scheduler.
package mqs_pkg;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_SCAN,
        S_RELOAD,
        S_GRANT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       mode;
        logic [2:0] level;
        logic [7:0] proc_id;
    } t_in;

    typedef struct packed {
        logic       grant_valid;
        logic [7:0] grant_id;
        logic [2:0] grant_level;
        logic       dropped;
        logic       all_empty;
    } t_out;

endpackage

>>> rtl/mqs_store.sv
// Identifier storage of all level queues, one write and one registered read port.
module mqs_store #(
    parameter int LEVELS      = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(LEVELS)-1:0]      i_wlvl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_wptr,
    input  logic [7:0]                     i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(LEVELS)-1:0]      i_rlvl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_rptr,
    output logic [7:0]                     o_rdata
);

    logic [7:0] r_mem [LEVELS][QUEUE_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wlvl][i_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_rlvl][i_rptr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/multilevel_quota_scheduler_top.sv
// Top level of the multilevel quota scheduler: sequencer, level state and result.
//
// Usage: drive i_item and raise start; the word is taken at a rising edge with
// start high and busy low. busy stays high until the result is out. The result
// word appears on o_result for exactly one cycle with o_done high; the receiver
// takes it at the end of that cycle and cannot hold it off.
// Enqueue (mode 0): after acceptance come the update state and then the result state;
// a new word can be taken once the block is back in idle.
// Dequeue (mode 1): one level is examined per cycle by a single scan index.
// All queues empty: result in the cycle right after acceptance. Otherwise the scan
// stops at the first level with entries and quota left; a quota reload sweep (when
// every non-empty level is out of quota) runs over all levels, then come the grant
// state for the identifier store read and the result state.
// Reset clears all pointers, fill counts and quotas and returns to idle;
// the identifier store is not cleared, since only written entries are read.
module multilevel_quota_scheduler_top #(
    parameter int LEVELS      = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mqs_pkg::t_in  i_item,
    output logic          o_done,
    output mqs_pkg::t_out o_result
);
    import mqs_pkg::*;

    localparam int LW = $clog2(LEVELS);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int QW = $clog2(LEVELS + 1);
    localparam int TW = $clog2(LEVELS * QUEUE_DEPTH + 1);
    localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_state r_state, n_state;

    logic [PW-1:0] r_head [LEVELS];
    logic [PW-1:0] n_head [LEVELS];
    logic [PW-1:0] r_tail [LEVELS];
    logic [PW-1:0] n_tail [LEVELS];
    logic [CW-1:0] r_fill [LEVELS];
    logic [CW-1:0] n_fill [LEVELS];
    logic [QW-1:0] r_quota [LEVELS];
    logic [QW-1:0] n_quota [LEVELS];
    logic [TW-1:0] r_total, n_total;

    logic [LW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_first, n_first;
    logic          r_first_ok, n_first_ok;
    logic          r_skip, n_skip;
    logic          r_lvl_ok, n_lvl_ok;
    logic [7:0]    r_pid, n_pid;
    logic          r_gv, n_gv;
    logic          r_drop, n_drop;

    logic          cur_full;
    logic          cur_eligible;
    logic          cur_waiting;
    logic          mem_we;
    logic          mem_re;
    logic [7:0]    mem_rdata;

    assign cur_full     = r_fill[r_idx] >= FULL_CNT;
    assign cur_eligible = (r_fill[r_idx] != '0) && (r_quota[r_idx] != '0);
    assign cur_waiting  = (r_fill[r_idx] != '0) && (r_quota[r_idx] == '0);
    assign mem_we       = (r_state == S_ENQ) && r_lvl_ok && !cur_full;
    assign mem_re       = (r_state == S_GRANT);

    mqs_store #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_wlvl  (r_idx),
        .i_wptr  (r_tail[r_idx]),
        .i_wdata (r_pid),
        .i_re    (mem_re),
        .i_rlvl  (r_idx),
        .i_rptr  (r_head[r_idx]),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.mode == MODE_ENQ) begin
                        n_state = S_ENQ;
                    end else if (r_total == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_ENQ:    n_state = S_DONE;
            S_SCAN: begin
                if (cur_eligible) begin
                    n_state = S_GRANT;
                end else if (r_idx == LAST_LVL) begin
                    n_state = S_RELOAD;
                end
            end
            S_RELOAD: begin
                if (r_idx == LAST_LVL) begin
                    n_state = S_GRANT;
                end
            end
            S_GRANT:  n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_quota    = r_quota;
        n_total    = r_total;
        n_idx      = r_idx;
        n_first    = r_first;
        n_first_ok = r_first_ok;
        n_skip     = r_skip;
        n_lvl_ok   = r_lvl_ok;
        n_pid      = r_pid;
        n_gv       = r_gv;
        n_drop     = r_drop;
        case (r_state)
            S_IDLE: begin
                n_gv       = 1'b0;
                n_drop     = 1'b0;
                n_skip     = 1'b0;
                n_first_ok = 1'b0;
                n_pid      = i_item.proc_id;
                n_lvl_ok   = 32'(i_item.level) < LEVELS;
                if (i_item.mode == MODE_ENQ) begin
                    n_idx = LW'(i_item.level);
                end else begin
                    n_idx = '0;
                end
            end
            S_ENQ: begin
                if (mem_we) begin
                    n_tail[r_idx] = (r_tail[r_idx] == LAST_PTR) ? '0 : r_tail[r_idx] + 1'b1;
                    n_fill[r_idx] = r_fill[r_idx] + 1'b1;
                    n_total       = r_total + 1'b1;
                end else begin
                    n_drop = 1'b1;
                end
            end
            S_SCAN: begin
                if (cur_waiting && !r_first_ok) begin
                    n_first    = r_idx;
                    n_first_ok = 1'b1;
                end
                if (!cur_eligible) begin
                    n_idx = (r_idx == LAST_LVL) ? '0 : r_idx + 1'b1;
                end
            end
            S_RELOAD: begin
                if (r_idx == r_first) begin
                    n_quota[r_idx] = QW'(LEVELS - 32'(r_idx) - 1);
                    n_skip         = 1'b1;
                end else begin
                    n_quota[r_idx] = QW'(LEVELS - 32'(r_idx));
                end
                n_idx = (r_idx == LAST_LVL) ? r_first : r_idx + 1'b1;
            end
            S_GRANT: begin
                n_gv          = 1'b1;
                n_head[r_idx] = (r_head[r_idx] == LAST_PTR) ? '0 : r_head[r_idx] + 1'b1;
                n_fill[r_idx] = r_fill[r_idx] - 1'b1;
                n_total       = r_total - 1'b1;
                if (!r_skip) begin
                    n_quota[r_idx] = r_quota[r_idx] - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_fill[i]  <= '0;
                r_quota[i] <= '0;
            end
            r_first_ok <= 1'b0;
            r_skip     <= 1'b0;
            r_gv       <= 1'b0;
            r_drop     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_quota    <= n_quota;
            r_first_ok <= n_first_ok;
            r_skip     <= n_skip;
            r_gv       <= n_gv;
            r_drop     <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_first  <= n_first;
        r_lvl_ok <= n_lvl_ok;
        r_pid    <= n_pid;
    end

    always_comb begin
        busy                 = (r_state != S_IDLE);
        o_done               = (r_state == S_DONE);
        o_result.grant_valid = r_gv;
        o_result.grant_id    = r_gv ? mem_rdata : 8'd0;
        o_result.grant_level = r_gv ? 3'(r_idx) : 3'd0;
        o_result.dropped     = r_drop;
        o_result.all_empty   = (r_total == '0);
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench of the multilevel quota scheduler: directed and random words checked against a predictor.
module testbench;
    import mqs_pkg::*;

    localparam int LEVELS       = 8;
    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_WORDS = 1330;
    localparam int PHASE_WORDS  = 50;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_done;
    t_out o_result;

    logic [7:0] id_store   [LEVELS][QUEUE_DEPTH];
    logic [3:0] head_pos   [LEVELS];
    logic [3:0] tail_pos   [LEVELS];
    logic [4:0] fill_cnt   [LEVELS];
    logic [3:0] quota_left [LEVELS];

    t_out pending_grants [$];
    int   errors  = 0;
    bit   gaps_on = 1'b1;

    multilevel_quota_scheduler_top #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit queues_empty();
        int i;
        for (i = 0; i < LEVELS; i++)
            if (fill_cnt[i] != 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int first_eligible();
        int i;
        for (i = 0; i < LEVELS; i++)
            if (fill_cnt[i] != 0 && quota_left[i] != 0) return i;
        return LEVELS;
    endfunction

    function automatic t_out predict_grant(t_in w);
        t_out r;
        int   sel;
        int   i;
        r = '0;
        if (w.mode == MODE_ENQ) begin
            if (fill_cnt[w.level] >= QUEUE_DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                id_store[w.level][tail_pos[w.level]] = w.proc_id;
                tail_pos[w.level] = (tail_pos[w.level] == QUEUE_DEPTH - 1) ?
                                    4'd0 : tail_pos[w.level] + 4'd1;
                fill_cnt[w.level] = fill_cnt[w.level] + 5'd1;
            end
        end else if (!queues_empty()) begin
            sel = first_eligible();
            if (sel == LEVELS) begin
                for (i = 0; i < LEVELS; i++)
                    quota_left[i] = 4'(LEVELS - i);
                sel = first_eligible();
            end
            if (sel < LEVELS) begin
                r.grant_valid = 1'b1;
                r.grant_id    = id_store[sel][head_pos[sel]];
                r.grant_level = 3'(sel);
                head_pos[sel] = (head_pos[sel] == QUEUE_DEPTH - 1) ? 4'd0 : head_pos[sel] + 4'd1;
                fill_cnt[sel]   = fill_cnt[sel] - 5'd1;
                quota_left[sel] = quota_left[sel] - 4'd1;
            end
        end
        r.all_empty = queues_empty();
        return r;
    endfunction

    function automatic t_in make_word(logic mode, int level, int id);
        t_in w;
        w.mode    = mode;
        w.level   = 3'(level);
        w.proc_id = 8'(id);
        return w;
    endfunction

    function automatic string show_result(t_out r);
        return $sformatf("valid=%0b id=%02h level=%0d dropped=%0b empty=%0b",
                         r.grant_valid, r.grant_id, r.grant_level, r.dropped, r.all_empty);
    endfunction

    task automatic flag_error(string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endtask

    task automatic send_word(t_in w);
        int gap;
        int pick;
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_grants.push_back(predict_grant(w));
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (gaps_on) begin
            if (pick < 40)      gap = 0;
            else if (pick < 85) gap = $urandom_range(1, 3);
            else if (pick < 97) gap = $urandom_range(4, 10);
            else                gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (pending_grants.size() == 0) begin
                flag_error($sformatf("unexpected word: %s", show_result(o_result)));
            end else begin
                want = pending_grants.pop_front();
                if (o_result.grant_valid !== want.grant_valid ||
                    o_result.grant_id    !== want.grant_id    ||
                    o_result.grant_level !== want.grant_level ||
                    o_result.dropped     !== want.dropped     ||
                    o_result.all_empty   !== want.all_empty) begin
                    flag_error($sformatf("mismatch: expected %s, got %s",
                                         show_result(want), show_result(o_result)));
                end
            end
        end
    end

    task automatic test_idle_dequeue();
        send_word(make_word(MODE_DEQ, 7, 255));
    endtask

    task automatic test_level_extremes();
        send_word(make_word(MODE_ENQ, 0, 0));
        send_word(make_word(MODE_ENQ, 7, 255));
        send_word(make_word(MODE_DEQ, 0, 0));
        send_word(make_word(MODE_DEQ, 7, 255));
        send_word(make_word(MODE_DEQ, 3, 8'h5a));
    endtask

    task automatic test_full_queue();
        int i;
        for (i = 0; i <= QUEUE_DEPTH; i++)
            send_word(make_word(MODE_ENQ, 5, 8'h80 + i));
        send_word(make_word(MODE_DEQ, 2, 8'hc3));
    endtask

    task automatic test_random_traffic();
        int sent;
        int enq_pct;
        int hot_level;
        bit focused;
        int lvl;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 3))
                0: enq_pct = 25;
                1: enq_pct = 50;
                2: enq_pct = 75;
                default: enq_pct = 90;
            endcase
            focused   = ($urandom_range(0, 2) == 0);
            hot_level = $urandom_range(0, LEVELS - 1);
            gaps_on   = ($urandom_range(0, 4) != 0);
            repeat (PHASE_WORDS) begin
                lvl = (focused && $urandom_range(0, 3) != 0) ? hot_level
                                                            : $urandom_range(0, LEVELS - 1);
                if ($urandom_range(0, 99) < enq_pct)
                    send_word(make_word(MODE_ENQ, lvl, $urandom_range(0, 255)));
                else
                    send_word(make_word(MODE_DEQ, lvl, $urandom_range(0, 255)));
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        int waited;
        int i;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        for (i = 0; i < LEVELS; i++) begin
            head_pos[i]   = '0;
            tail_pos[i]   = '0;
            fill_cnt[i]   = '0;
            quota_left[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_dequeue();
        test_level_extremes();
        test_full_queue();
        test_random_traffic();

        start <= 1'b0;
        waited = 0;
        while (pending_grants.size() != 0 && waited < 500) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * LEVELS + 8) @(posedge i_clk);
        if (pending_grants.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", pending_grants.size()));
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
